// ===== hdl/tah_pkg.sv =====
// Shared constants, types and the calibration function of the throttle averaging filter.
package tah_pkg;

    // Ring depth (a power of two) and the derived shift for the average.
    localparam int DEPTH      = 16;
    localparam int DEPTH_LOG2 = $clog2(DEPTH);

    // Field widths.
    localparam int ADC_W   = 12;
    localparam int LEVEL_W = 15;
    localparam int CAL_W   = 17;
    localparam int SUM_W   = CAL_W + DEPTH_LOG2;
    localparam int CMP_W   = CAL_W + 1;
    localparam int IDX_W   = 8;

    // Calibration offset and upper clamp, in 1/256 percent.
    localparam int CAL_OFFSET = 6516;
    localparam int LEVEL_MAX  = 25600;

    // Register indexes and reset values.
    localparam logic [IDX_W-1:0]   CFG_ACTIVATE_LEVEL = IDX_W'(0);
    localparam logic [IDX_W-1:0]   CFG_RELEASE_WIDTH  = IDX_W'(1);
    localparam logic [LEVEL_W-1:0] ACTIVATE_RESET     = LEVEL_W'(1280);
    localparam logic [LEVEL_W-1:0] RELEASE_RESET      = LEVEL_W'(512);

    typedef logic signed [CAL_W-1:0] cal_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Window stage to threshold stage: pending flag and the running sum.
    typedef struct packed {
        logic valid;
        sum_t sum;
    } win_stage_t;

    // floor(adc * 25 / 2) - offset, with 25 * adc built from shifts.
    function automatic cal_t calibrate(input logic [ADC_W-1:0] adc);
        logic [ADC_W+4:0] prod;
        logic [ADC_W+3:0] half;
        prod = {adc, 4'b0000} + {1'b0, adc, 3'b000} + {5'b00000, adc};
        half = prod[ADC_W+4:1];
        return cal_t'({1'b0, half}) - cal_t'(CAL_OFFSET);
    endfunction

endpackage

// ===== hdl/throttle_average_hysteresis.sv =====
// Throttle averaging filter with hysteresis threshold, top level.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_adc_sample[11:0]
//  m_       out        m_valid/m_ready    m_throttle_level[14:0], m_active
//  cfg_     in         cfg_valid/cfg_ready cfg_index[7:0], cfg_data[14:0]
//
// One item per cycle unless m_ stalls; an item is registered in the
// running sum, then in the result register. These and the window cells are
// separate stages, so an item can be taken while an earlier result waits at
// m_ if the sum stage is empty. Synchronous reset clears the window, the sum,
// the flag and sets the config defaults. The config port is always ready.
module throttle_average_hysteresis
    import tah_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ADC_W-1:0]   s_adc_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_throttle_level,
    output logic               m_active,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [LEVEL_W-1:0] cfg_data
);

    win_stage_t         win_stage;
    logic               hyst_ready;
    logic [LEVEL_W-1:0] activate_reg;
    logic [LEVEL_W-1:0] activate_next;
    logic [LEVEL_W-1:0] release_reg;
    logic [LEVEL_W-1:0] release_next;

    assign cfg_ready = 1'b1;

    // Register decode; unknown indexes are ignored.
    always_comb begin
        activate_next = activate_reg;
        release_next  = release_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ACTIVATE_LEVEL: activate_next = cfg_data;
                CFG_RELEASE_WIDTH:  release_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            activate_reg <= ACTIVATE_RESET;
            release_reg  <= RELEASE_RESET;
        end else begin
            activate_reg <= activate_next;
            release_reg  <= release_next;
        end
    end

    tah_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_adc_sample(s_adc_sample),
        .stage_ready (hyst_ready),
        .stage_out   (win_stage)
    );

    tah_hyst u_hyst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .stage_in        (win_stage),
        .stage_ready     (hyst_ready),
        .activate_level  (activate_reg),
        .release_width   (release_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_throttle_level(m_throttle_level),
        .m_active        (m_active)
    );

endmodule

// ===== hdl/tah_cell.sv =====
// One cell of the sample window: holds one calibrated sample and passes it on.
module tah_cell
    import tah_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic shift_en,
    input  cal_t sample_in,
    output cal_t sample_out
);

    cal_t sample_reg;
    cal_t sample_next;

    // Take the neighbor's sample when an item moves the window.
    always_comb begin
        sample_next = shift_en ? sample_in : sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

// ===== hdl/tah_window.sv =====
// Calibration, the chain of window cells and the running sum.
module tah_window
    import tah_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ADC_W-1:0] s_adc_sample,
    input  logic             stage_ready,
    output win_stage_t       stage_out
);

    cal_t       cal;
    logic       accept;
    cal_t       chain [DEPTH+1];
    logic       valid_reg;
    logic       valid_next;
    sum_t       sum_reg;
    sum_t       sum_next;

    assign cal    = calibrate(s_adc_sample);
    assign s_ready = !valid_reg || stage_ready;
    assign accept = s_valid && s_ready;

    // The newest sample enters cell 0; the last cell holds the sample
    // that leaves the window.
    assign chain[0] = cal;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tah_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (accept),
            .sample_in (chain[i]),
            .sample_out(chain[i+1])
        );
    end

    // Running sum: add the new sample, drop the oldest.
    always_comb begin
        sum_next   = sum_reg;
        valid_next = valid_reg && !stage_ready;
        if (accept) begin
            sum_next   = sum_reg + sum_t'(cal) - sum_t'(chain[DEPTH]);
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.sum   = sum_reg;

endmodule

// ===== hdl/tah_hyst.sv =====
// Average, clamp, hysteresis flag and the result register.
module tah_hyst
    import tah_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  win_stage_t         stage_in,
    output logic               stage_ready,
    input  logic [LEVEL_W-1:0] activate_level,
    input  logic [LEVEL_W-1:0] release_width,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_throttle_level,
    output logic               m_active
);

    localparam cal_t MAX_AVG = cal_t'(LEVEL_MAX);

    sum_t                     avg_wide;
    cal_t                     avg;
    cal_t                     avg_clamped;
    logic signed [CMP_W-1:0]  avg_ext;
    logic signed [CMP_W-1:0]  act_ext;
    logic signed [CMP_W-1:0]  release_lvl;
    logic                     take;
    logic                     active_reg;
    logic                     active_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic [LEVEL_W-1:0]       level_reg;
    logic [LEVEL_W-1:0]       level_next;

    assign stage_ready = !valid_reg || m_ready;
    assign take        = stage_in.valid && stage_ready;

    // Floor average by arithmetic shift, clamped from above only.
    always_comb begin
        avg_wide    = stage_in.sum >>> DEPTH_LOG2;
        avg         = avg_wide[CAL_W-1:0];
        avg_clamped = (avg > MAX_AVG) ? MAX_AVG : avg;
        avg_ext     = CMP_W'(avg_clamped);
        act_ext     = signed'({{(CMP_W-LEVEL_W){1'b0}}, activate_level});
        release_lvl = act_ext - signed'({{(CMP_W-LEVEL_W){1'b0}}, release_width});
    end

    // Hysteresis update and the result for this item.
    always_comb begin
        active_next = active_reg;
        level_next  = level_reg;
        valid_next  = valid_reg && !m_ready;
        if (take) begin
            if (avg_ext > act_ext) begin
                active_next = 1'b1;
            end else if (avg_ext < release_lvl) begin
                active_next = 1'b0;
            end
            if (active_next && (avg_clamped > cal_t'(0))) begin
                level_next = avg_clamped[LEVEL_W-1:0];
            end else begin
                level_next = '0;
            end
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg <= level_next;
    end

    assign m_valid          = valid_reg;
    assign m_throttle_level = level_reg;
    assign m_active         = active_reg;

endmodule

// ===== hdl/tah_checker.sv =====
// Port-level checks of the throttle filter and their bind to the top level.
module tah_checker
    import tah_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [LEVEL_W-1:0] m_throttle_level,
    input logic               m_active
);

    // No result is offered right after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A nonzero level is only given while the flag is set.
    a_level_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_throttle_level != '0)) |-> m_active)
        else $error("nonzero level while inactive");

    // The level never exceeds full throttle.
    a_level_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_throttle_level <= LEVEL_W'(LEVEL_MAX)))
        else $error("level above clamp");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_throttle_level) && $stable(m_active)))
        else $error("stalled result changed");

endmodule

bind throttle_average_hysteresis tah_checker u_tah_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_throttle_level(m_throttle_level),
    .m_active        (m_active)
);
